/* rtl/pss_pkg.sv */
// Shared types, codes, reset values and the source priority function.
`default_nettype none
package pss_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 12;
	localparam int unsigned CFG_DATA_BITS   = 16;
	localparam int unsigned CFG_INDEX_BITS  = 3;
	localparam int unsigned HOLDOFF_BITS    = 16;
	localparam int unsigned DEBOUNCE_BITS   = 8;
	localparam int unsigned PRESET_BITS     = 3;

	typedef logic [1:0] op_t;
	typedef logic [1:0] src_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_AC    = 2'd1;
	localparam op_t OP_BAT   = 2'd2;
	localparam op_t OP_PANEL = 2'd3;

	localparam src_t SRC_AC    = 2'd0;
	localparam src_t SRC_BAT   = 2'd1;
	localparam src_t SRC_PANEL = 2'd2;
	localparam src_t SRC_NONE  = 2'd3;

	localparam cfg_index_t REG_PRIORITY_PRESET = 3'd0;
	localparam cfg_index_t REG_AC_PEAK_LOW     = 3'd1;
	localparam cfg_index_t REG_AC_PEAK_HIGH    = 3'd2;
	localparam cfg_index_t REG_BATTERY_LOW     = 3'd3;
	localparam cfg_index_t REG_PANEL_LOW       = 3'd4;
	localparam cfg_index_t REG_HOLDOFF_MS      = 3'd5;
	localparam cfg_index_t REG_DEBOUNCE_MS     = 3'd6;

	localparam int unsigned PRESET_RST      = 0;
	localparam int unsigned AC_PEAK_LOW_RST  = 3350;
	localparam int unsigned AC_PEAK_HIGH_RST = 3860;
	localparam int unsigned BATTERY_LOW_RST  = 2000;
	localparam int unsigned PANEL_LOW_RST    = 2500;
	localparam int unsigned HOLDOFF_MS_RST   = 5000;
	localparam int unsigned DEBOUNCE_MS_RST  = 40;

	localparam int unsigned PRESET_COUNT = 6;
	localparam logic [PRESET_BITS-1:0] PRESET_MAX = 3'd5;

	localparam src_t PRIO_TABLE [PRESET_COUNT][3] = '{
		'{SRC_AC,    SRC_BAT,   SRC_PANEL},
		'{SRC_AC,    SRC_PANEL, SRC_BAT},
		'{SRC_BAT,   SRC_AC,    SRC_PANEL},
		'{SRC_BAT,   SRC_PANEL, SRC_AC},
		'{SRC_PANEL, SRC_AC,    SRC_BAT},
		'{SRC_PANEL, SRC_BAT,   SRC_AC}
	};

	// First available source in preset order; none when disabled or preset undefined.
	function automatic src_t pick_source(
		input logic [PRESET_BITS-1:0] preset,
		input logic                   enable,
		input logic                   ac_ok,
		input logic                   bat_ok,
		input logic                   pan_ok
	);
		src_t       s;
		src_t       pick;
		logic [3:0] avail;
		pick  = SRC_NONE;
		avail = {1'b0, pan_ok, bat_ok, ac_ok};
		if (enable && preset <= PRESET_MAX) begin
			// walk lowest priority first so the highest available wins
			for (int i = 2; i >= 0; i--) begin
				s = PRIO_TABLE[preset][i];
				if (avail[s]) begin
					pick = s;
				end
			end
		end
		return pick;
	endfunction

endpackage
`default_nettype wire

/* rtl/pss_item_if.sv */
// Input word channel: valid/ready with tick or sample payload.
`default_nettype none
interface pss_item_if #(
	parameter int unsigned SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	pss_pkg::op_t           operation;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   window_last;
	logic                   button_low;

	modport source (output valid, operation, sample, window_last, button_low, input ready);
	modport sink (input valid, operation, sample, window_last, button_low, output ready);
endinterface
`default_nettype wire

/* rtl/pss_result_if.sv */
// Result word channel: valid/ready with selected source and status.
`default_nettype none
interface pss_result_if #(
	parameter int unsigned SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	pss_pkg::src_t          source_sel;
	logic                   ac_present;
	logic                   battery_present;
	logic                   panel_present;
	logic                   output_enabled;
	logic [SAMPLE_BITS-1:0] ac_window_peak;

	modport source (output valid, source_sel, ac_present, battery_present, panel_present,
		output_enabled, ac_window_peak, input ready);
	modport sink (input valid, source_sel, ac_present, battery_present, panel_present,
		output_enabled, ac_window_peak, output ready);
endinterface
`default_nettype wire

/* rtl/pss_button.sv */
// Push-button debounce machine that toggles the output enable on ticks.
`default_nettype none
module pss_button (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic                                pressed,
	input  wire logic [pss_pkg::DEBOUNCE_BITS-1:0]   debounce_ms,
	output logic                                     enable_next
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_DBC     = 2'd1;
	localparam logic [1:0] PH_PRESSED = 2'd2;

	logic [1:0]                          phase_q, phase_d;
	logic [pss_pkg::DEBOUNCE_BITS-1:0]   dbc_q, dbc_d, dbc_dec;
	logic                                en_q, en_d;

	always_comb begin
		dbc_dec = (dbc_q != '0) ? dbc_q - 1'b1 : dbc_q;
		dbc_d   = dbc_dec;
		phase_d = phase_q;
		en_d    = en_q;
		unique case (phase_q)
			PH_DBC: begin
				if (dbc_dec == '0) begin
					if (pressed) begin
						phase_d = PH_PRESSED;
						en_d    = ~en_q;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// unused code falls back to idle
				phase_d = PH_IDLE;
				if (pressed) begin
					dbc_d   = debounce_ms;
					phase_d = PH_DBC;
				end
			end
		endcase
		enable_next = step ? en_d : en_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dbc_q   <= '0;
			en_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			dbc_q   <= dbc_d;
			en_q    <= en_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/power_source_selector.sv */
// Top level: AC peak window check, sample thresholds, holdoff and source choice.
//
//   channel  dir  handshake      payload
//   item     in   valid/ready    operation, sample, window_last, button_low
//   result   out  valid/ready    source_sel, ac/battery/panel_present, output_enabled,
//                                ac_window_peak
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// One word per cycle sustained while results are taken; each word is registered
// in the input register, then processed into the result register.
// Flags and state reset to zero/idle, config registers to defaults on arst_n; payloads do not.
// A stalled result holds; the input register still takes one more word, then
// ready drops until the result is taken.
`default_nettype none
module power_source_selector #(
	parameter int unsigned SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [pss_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	pss_item_if.sink                                  item,
	pss_result_if.source                              result
);

	// configuration registers
	logic [pss_pkg::PRESET_BITS-1:0]   preset_q;
	logic [SAMPLE_BITS-1:0]            ac_low_q, ac_high_q, bat_low_q, pan_low_q;
	logic [pss_pkg::HOLDOFF_BITS-1:0]  holdoff_ms_q;
	logic [pss_pkg::DEBOUNCE_BITS-1:0] debounce_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q      <= pss_pkg::PRESET_BITS'(pss_pkg::PRESET_RST);
			ac_low_q      <= SAMPLE_BITS'(pss_pkg::AC_PEAK_LOW_RST);
			ac_high_q     <= SAMPLE_BITS'(pss_pkg::AC_PEAK_HIGH_RST);
			bat_low_q     <= SAMPLE_BITS'(pss_pkg::BATTERY_LOW_RST);
			pan_low_q     <= SAMPLE_BITS'(pss_pkg::PANEL_LOW_RST);
			holdoff_ms_q  <= pss_pkg::HOLDOFF_BITS'(pss_pkg::HOLDOFF_MS_RST);
			debounce_ms_q <= pss_pkg::DEBOUNCE_BITS'(pss_pkg::DEBOUNCE_MS_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				pss_pkg::REG_PRIORITY_PRESET: preset_q <= cfg_data[pss_pkg::PRESET_BITS-1:0];
				pss_pkg::REG_AC_PEAK_LOW:     ac_low_q <= cfg_data[SAMPLE_BITS-1:0];
				pss_pkg::REG_AC_PEAK_HIGH:    ac_high_q <= cfg_data[SAMPLE_BITS-1:0];
				pss_pkg::REG_BATTERY_LOW:     bat_low_q <= cfg_data[SAMPLE_BITS-1:0];
				pss_pkg::REG_PANEL_LOW:       pan_low_q <= cfg_data[SAMPLE_BITS-1:0];
				pss_pkg::REG_HOLDOFF_MS:
					holdoff_ms_q <= cfg_data[pss_pkg::HOLDOFF_BITS-1:0];
				pss_pkg::REG_DEBOUNCE_MS:
					debounce_ms_q <= cfg_data[pss_pkg::DEBOUNCE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                   valid_s1;
	pss_pkg::op_t           op_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;
	logic                   pressed_s1;

	logic res_valid_q;
	logic advance;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1      <= item.operation;
			sample_s1  <= item.sample;
			last_s1    <= item.window_last;
			pressed_s1 <= item.button_low;
		end
	end

	// processing state
	logic [SAMPLE_BITS-1:0]           run_peak_q, run_peak_d;
	logic [SAMPLE_BITS-1:0]           last_peak_q, last_peak_d;
	logic                             ac_q, ac_d, bat_q, bat_d, pan_q, pan_d;
	logic [pss_pkg::HOLDOFF_BITS-1:0] holdoff_q, holdoff_d;
	logic [SAMPLE_BITS-1:0]           peak;
	logic                             enable_next;
	pss_pkg::src_t                    source_d;

	pss_button u_button (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance && op_s1 == pss_pkg::OP_TICK),
		.pressed     (pressed_s1),
		.debounce_ms (debounce_ms_q),
		.enable_next (enable_next)
	);

	always_comb begin
		peak        = (sample_s1 > run_peak_q) ? sample_s1 : run_peak_q;
		run_peak_d  = run_peak_q;
		last_peak_d = last_peak_q;
		ac_d        = ac_q;
		bat_d       = bat_q;
		pan_d       = pan_q;
		holdoff_d   = holdoff_q;
		unique case (op_s1)
			pss_pkg::OP_TICK: begin
				if (holdoff_q != '0) begin
					holdoff_d = holdoff_q - 1'b1;
				end
			end
			pss_pkg::OP_AC: begin
				if (last_s1) begin
					ac_d = (peak > ac_low_q) && (peak < ac_high_q);
					if (!ac_d) begin
						holdoff_d = holdoff_ms_q;
					end
					last_peak_d = peak;
					run_peak_d  = '0;
				end else begin
					run_peak_d = peak;
				end
			end
			pss_pkg::OP_BAT:   bat_d = sample_s1 > bat_low_q;
			pss_pkg::OP_PANEL: pan_d = sample_s1 > pan_low_q;
		endcase
		source_d = pss_pkg::pick_source(preset_q, enable_next,
			ac_d && (holdoff_d == '0), bat_d, pan_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_peak_q  <= '0;
			last_peak_q <= '0;
			ac_q        <= 1'b0;
			bat_q       <= 1'b0;
			pan_q       <= 1'b0;
			holdoff_q   <= '0;
		end else if (advance) begin
			run_peak_q  <= run_peak_d;
			last_peak_q <= last_peak_d;
			ac_q        <= ac_d;
			bat_q       <= bat_d;
			pan_q       <= pan_d;
			holdoff_q   <= holdoff_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.source_sel      <= source_d;
			result.ac_present      <= ac_d;
			result.battery_present <= bat_d;
			result.panel_present   <= pan_d;
			result.output_enabled  <= enable_next;
			result.ac_window_peak  <= last_peak_d;
		end
	end

	assign result.valid = res_valid_q;

endmodule
`default_nettype wire
